// ===== src/sel_pkg.sv =====
package sel_pkg;

    // defaults for the top-level parameters
    localparam int GRID_SIDE_DEF = 256;
    localparam int PARTICLES_DEF = 16;
    // readings per scan; the reading number field is fixed at 11 bits
    localparam int SCAN_READINGS = 1080;

    // beam angle in 2^-32 turn
    localparam logic [31:0] BEAM_STEP   = 32'd2982395;
    localparam logic [31:0] BEAM_OFFSET = 32'd2687337176;
    localparam logic [15:0] CORDIC_KQ16 = 16'd39797;

    // weight clamp, Q7.16
    localparam int SUM_W = 26;
    localparam logic signed [SUM_W-1:0] LOW_LIMIT  = -26'sd2177059;
    localparam logic signed [SUM_W-1:0] LOW_SET    = -26'sd2242595;
    localparam logic signed [SUM_W-1:0] HIGH_LIMIT = 26'sd2177058;
    localparam logic signed [SUM_W-1:0] HIGH_SET   = 26'sd2329229;
    localparam logic signed [15:0]      ZERO_PROB  = -16'sd32768;

    localparam int COR_W        = 35;   // CORDIC x/y
    localparam int ANG_W        = 34;   // CORDIC residual angle
    localparam int CORDIC_STEPS = 16;
    localparam int DIV_W        = 28;   // dividend/quotient
    localparam int DSR_W        = 16;   // divisor

    // register map, index = paddr[4:2]
    localparam logic [2:0] REG_ORIGIN_X    = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Y    = 3'd1;
    localparam logic [2:0] REG_CELL_SIZE_X = 3'd2;
    localparam logic [2:0] REG_CELL_SIZE_Y = 3'd3;
    localparam logic [2:0] REG_MAX_RANGE   = 3'd4;
    localparam logic [2:0] REG_LOG_GAIN    = 3'd5;

    localparam logic CMD_MAP_WRITE = 1'b0;
    localparam logic CMD_BEAM      = 1'b1;

    typedef struct packed {
        logic               command;
        logic [3:0]         particle;
        logic [7:0]         cell_x;
        logic [7:0]         cell_y;
        logic signed [15:0] cell_value;
        logic signed [23:0] pose_x;
        logic signed [23:0] pose_y;
        logic [15:0]        pose_angle;
        logic [10:0]        reading_index;
        logic [15:0]        range_reading;
        logic               first_beam;
        logic               last_beam;
    } in_item_t;

    typedef struct packed {
        logic [3:0]         particle_out;
        logic signed [23:0] weight_log2;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ANGLE,
        ST_START,
        ST_ROTATE,
        ST_PREP,
        ST_DSTART,
        ST_DIVIDE,
        ST_LOOKUP,
        ST_ACCUM,
        ST_FINISH
    } state_t;

    // atan(2^-i) in 2^-32 turn
    function automatic logic signed [ANG_W-1:0] atan_turn(input logic [3:0] i);
        logic signed [ANG_W-1:0] r;
        unique case (i)
            4'd0:    r = 34'sd536870912;
            4'd1:    r = 34'sd316933406;
            4'd2:    r = 34'sd167458908;
            4'd3:    r = 34'sd85004756;
            4'd4:    r = 34'sd42667332;
            4'd5:    r = 34'sd21354465;
            4'd6:    r = 34'sd10679842;
            4'd7:    r = 34'sd5340245;
            4'd8:    r = 34'sd2670163;
            4'd9:    r = 34'sd1335087;
            4'd10:   r = 34'sd667544;
            4'd11:   r = 34'sd333772;
            4'd12:   r = 34'sd166886;
            4'd13:   r = 34'sd83443;
            4'd14:   r = 34'sd41722;
            default: r = 34'sd20861;
        endcase
        return r;
    endfunction

    // 11-bit value divisible by 3 (4 = 1 mod 3, so fold 2-bit digits)
    function automatic logic is_mult3(input logic [10:0] v);
        logic [4:0] s1;
        logic [2:0] s2;
        s1 = 5'(v[1:0]) + 5'(v[3:2]) + 5'(v[5:4]) + 5'(v[7:6]) + 5'(v[9:8]) + 5'(v[10]);
        s2 = 3'(s1[4]) + 3'(s1[3:2]) + 3'(s1[1:0]);
        return (s2 == 3'd0) || (s2 == 3'd3) || (s2 == 3'd6);
    endfunction

endpackage

// ===== src/scan_endpoint_likelihood_top.sv =====
// Laser scan endpoint likelihood against per-particle occupancy grids.
// Input channel s_valid/s_ready/s_payload carries one item at a time:
//   map write (command 0) stores a Q5.10 log2 cell probability in the grid
//   memory; beam (command 1) scores one range reading.
// Result channel m_valid/m_ready/m_payload gives particle and Q7.16 log2
// weight once, on the beam item flagged last_beam.
// Timing: one item in flight. A skipped beam (wrong reading number or range
// at/over max_range) passes the angle and start states to finish. A used beam
// runs the 16-step CORDIC (one micro-rotation a cycle) and then the 28-bit
// restoring dividers for the grid index (x and y run side by side),
// followed by one grid memory read and the log-domain accumulate.
// The result sits in an output register; the block keeps taking items while
// it waits. Only a second last_beam item stalls, in its final cycle, until
// the earlier result is taken.
// Configuration over the APB-style port, six 32-bit registers at 4*i.
// Reset (aresetn low, synchronous) returns the registers to their defaults,
// zeroes the weight and drops m_valid; grid contents are not cleared and
// must be written before they are read.
module scan_endpoint_likelihood_top #(
    parameter int GRID_SIDE = sel_pkg::GRID_SIDE_DEF,
    parameter int PARTICLES = sel_pkg::PARTICLES_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    // input items
    input  logic               s_valid,
    output logic               s_ready,
    input  sel_pkg::in_item_t  s_payload,
    // results
    output logic               m_valid,
    input  logic               m_ready,
    output sel_pkg::out_item_t m_payload,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import sel_pkg::*;

    localparam int DEPTH = PARTICLES * GRID_SIDE * GRID_SIDE;
    localparam int AW    = $clog2(DEPTH);
    localparam int GW    = $clog2(GRID_SIDE);

    // config registers
    logic signed [23:0] origin_x_reg, origin_y_reg;
    logic [15:0]        cell_size_x_reg, cell_size_y_reg, max_range_reg;
    logic signed [16:0] log_gain_reg;
    logic               cfg_we;

    state_t             state_reg, state_next;
    in_item_t           item_reg;
    logic [31:0]        angle_reg;
    logic               used_reg;
    logic signed [DIV_W-1:0] mx_reg, my_reg;
    logic               inmap_reg;
    logic signed [23:0] weight_reg, weight_next;
    logic               m_valid_reg, m_valid_next;
    out_item_t          m_payload_reg;

    logic               s_acc;
    logic               cor_start, cor_done;
    logic               div_start, divx_done, divy_done;
    logic signed [COR_W-1:0] cor_x, cor_y;
    logic [DIV_W-1:0]   qx, qy, dvx, dvy;
    logic [15:0]        sx_eff, sy_eff;
    logic               emit;

    logic [11:0]        wtr;
    logic [31:0]        angle_c;
    logic               used_c;
    logic signed [COR_W:0] ndx, ndy;
    logic signed [DIV_W-1:0] mx_c, my_c;
    logic               inx, iny, inmap_c;
    logic [GW-1:0]      ix, iy;

    logic               ram_we;
    logic [AW-1:0]      ram_addr, waddr, raddr;
    logic [15:0]        ram_rdata;
    logic               wr_ok;
    logic signed [15:0] cval;
    logic signed [SUM_W-1:0] sum, clamped;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_x_reg    <= '0;
            origin_y_reg    <= '0;
            cell_size_x_reg <= 16'd256;
            cell_size_y_reg <= 16'd256;
            max_range_reg   <= 16'd7680;
            log_gain_reg    <= 17'sd24806;
        end else if (cfg_we) begin
            unique case (paddr[4:2])
                REG_ORIGIN_X:    origin_x_reg    <= pwdata[23:0];
                REG_ORIGIN_Y:    origin_y_reg    <= pwdata[23:0];
                REG_CELL_SIZE_X: cell_size_x_reg <= pwdata[15:0];
                REG_CELL_SIZE_Y: cell_size_y_reg <= pwdata[15:0];
                REG_MAX_RANGE:   max_range_reg   <= pwdata[15:0];
                REG_LOG_GAIN:    log_gain_reg    <= pwdata[16:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_ORIGIN_X:    prdata = {8'd0, origin_x_reg};
            REG_ORIGIN_Y:    prdata = {8'd0, origin_y_reg};
            REG_CELL_SIZE_X: prdata = {16'd0, cell_size_x_reg};
            REG_CELL_SIZE_Y: prdata = {16'd0, cell_size_y_reg};
            REG_MAX_RANGE:   prdata = {16'd0, max_range_reg};
            REG_LOG_GAIN:    prdata = {15'd0, log_gain_reg};
            default:         prdata = '0;
        endcase
    end

    // zero cell size acts as one
    assign sx_eff = (cell_size_x_reg == '0) ? 16'd1 : cell_size_x_reg;
    assign sy_eff = (cell_size_y_reg == '0) ? 16'd1 : cell_size_y_reg;

    // ---------------- sequencer ----------------
    assign s_ready = (state_reg == ST_IDLE);
    assign s_acc   = s_valid && s_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (s_acc && s_payload.command == CMD_BEAM) begin
                state_next = ST_ANGLE;
            end
            ST_ANGLE:  state_next = ST_START;
            ST_START:  state_next = used_reg ? ST_ROTATE : ST_FINISH;
            ST_ROTATE: if (cor_done) begin
                state_next = ST_PREP;
            end
            ST_PREP:   state_next = ST_DSTART;
            ST_DSTART: state_next = ST_DIVIDE;
            ST_DIVIDE: if (divx_done && divy_done) begin
                state_next = ST_LOOKUP;
            end
            ST_LOOKUP: state_next = ST_ACCUM;
            ST_ACCUM:  state_next = ST_FINISH;
            ST_FINISH: if (!item_reg.last_beam || !m_valid_reg || m_ready) begin
                state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cor_start = (state_reg == ST_START) && used_reg;
        div_start = (state_reg == ST_DSTART);
        emit      = (state_reg == ST_FINISH) && item_reg.last_beam &&
                    (!m_valid_reg || m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // ---------------- beam geometry ----------------
    always_comb begin
        wtr     = 12'(item_reg.reading_index) + 12'd1;
        angle_c = {item_reg.pose_angle, 16'h0000} + 32'(wtr * 34'(BEAM_STEP)) + BEAM_OFFSET;
        used_c  = (int'(item_reg.reading_index) < SCAN_READINGS - 2) &&
                  is_mult3(item_reg.reading_index) &&
                  (item_reg.range_reading < max_range_reg);
        // floor(-n / 2^16) with n = (pose - origin) * 2^16 + d
        ndx  = -(COR_W+1)'(cor_x);
        ndy  = -(COR_W+1)'(cor_y);
        mx_c = DIV_W'(origin_x_reg) - DIV_W'(item_reg.pose_x) + DIV_W'(ndx >>> 16);
        my_c = DIV_W'(origin_y_reg) - DIV_W'(item_reg.pose_y) + DIV_W'(ndy >>> 16);
        // ceil(n/d): -(M/s) for M >= 0 (never inside), else ceil(|M|/s)
        dvx  = mx_reg[DIV_W-1] ? DIV_W'(-mx_reg) + DIV_W'(sx_eff) - DIV_W'(1)
                               : DIV_W'(mx_reg);
        dvy  = my_reg[DIV_W-1] ? DIV_W'(-my_reg) + DIV_W'(sy_eff) - DIV_W'(1)
                               : DIV_W'(my_reg);
        inx  = mx_reg[DIV_W-1] && (qx != '0) && (qx < DIV_W'(GRID_SIDE));
        iny  = my_reg[DIV_W-1] && (qy != '0) && (qy < DIV_W'(GRID_SIDE));
        inmap_c = inx && iny && (int'(item_reg.particle) < PARTICLES);
        ix   = GW'(qx - DIV_W'(1));
        iy   = GW'(qy - DIV_W'(1));
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            item_reg <= s_payload;
        end
        if (state_reg == ST_ANGLE) begin
            angle_reg <= angle_c;
            used_reg  <= used_c;
        end
        if (state_reg == ST_PREP) begin
            mx_reg <= mx_c;
            my_reg <= my_c;
        end
        if (state_reg == ST_LOOKUP) begin
            inmap_reg <= inmap_c;
        end
    end

    sel_cordic u_cordic (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cor_start),
        .angle    (angle_reg),
        .range_in (item_reg.range_reading),
        .done     (cor_done),
        .x_out    (cor_x),
        .y_out    (cor_y)
    );

    sel_div u_div_x (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (dvx),
        .divisor  (sx_eff),
        .done     (divx_done),
        .quotient (qx)
    );

    sel_div u_div_y (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (dvy),
        .divisor  (sy_eff),
        .done     (divy_done),
        .quotient (qy)
    );

    // ---------------- grid memory ----------------
    always_comb begin
        wr_ok = (s_payload.command == CMD_MAP_WRITE) &&
                (int'(s_payload.particle) < PARTICLES) &&
                (int'(s_payload.cell_x) < GRID_SIDE) &&
                (int'(s_payload.cell_y) < GRID_SIDE);
        waddr = AW'(s_payload.particle) * AW'(GRID_SIDE * GRID_SIDE) +
                AW'(s_payload.cell_y) * AW'(GRID_SIDE) + AW'(s_payload.cell_x);
        raddr = AW'(item_reg.particle) * AW'(GRID_SIDE * GRID_SIDE) +
                AW'(iy) * AW'(GRID_SIDE) + AW'(ix);
        ram_we   = s_acc && wr_ok;
        ram_addr = (state_reg == ST_LOOKUP) ? raddr : waddr;
    end

    sel_ram #(
        .WIDTH (16),
        .DEPTH (DEPTH)
    ) u_grid (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (s_payload.cell_value),
        .rdata (ram_rdata)
    );

    // ---------------- weight accumulate and clamp ----------------
    always_comb begin
        cval = $signed(ram_rdata);
        if (!inmap_reg) begin
            sum = SUM_W'(weight_reg);
        end else if (cval == ZERO_PROB) begin
            sum = LOW_SET;
        end else begin
            sum = SUM_W'(weight_reg) + SUM_W'(log_gain_reg) + (SUM_W'(cval) <<< 6);
        end
        priority if (sum < LOW_LIMIT) begin
            clamped = LOW_SET;
        end else if (sum > HIGH_LIMIT) begin
            clamped = HIGH_SET;
        end else begin
            clamped = sum;
        end

        weight_next = weight_reg;
        if (s_acc && s_payload.command == CMD_BEAM && s_payload.first_beam) begin
            weight_next = '0;
        end else if (state_reg == ST_ACCUM) begin
            weight_next = clamped[23:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            weight_reg <= '0;
        end else begin
            weight_reg <= weight_next;
        end
    end

    // ---------------- result register ----------------
    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        if (emit) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_payload_reg.particle_out <= item_reg.particle;
            m_payload_reg.weight_log2  <= weight_reg;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;
endmodule

// ===== src/sel_ram.sv =====
module sel_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;
endmodule

// ===== src/sel_cordic.sv =====
module sel_cordic (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic [31:0]                      angle,
    input  logic [15:0]                      range_in,
    output logic                             done,
    output logic signed [sel_pkg::COR_W-1:0] x_out,
    output logic signed [sel_pkg::COR_W-1:0] y_out
);
    import sel_pkg::*;

    logic signed [COR_W-1:0] x_reg, x_next, y_reg, y_next;
    logic signed [ANG_W-1:0] z_reg, z_next;
    logic [3:0]              step_reg, step_next;
    logic                    busy_reg, busy_next, done_reg, done_next;

    logic                    fold;
    logic [31:0]             a_f;
    logic [31:0]             prod;
    logic signed [COR_W-1:0] dx, dy;

    always_comb begin
        // second and third quadrants: negate and turn by half a turn
        fold = angle[31] ^ angle[30];
        a_f  = fold ? (angle ^ 32'h8000_0000) : angle;
        prod = 32'(range_in) * 32'(CORDIC_KQ16);
        dx   = y_reg >>> step_reg;
        dy   = x_reg >>> step_reg;

        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        if (start) begin
            x_next = fold ? -$signed({3'b000, prod}) : $signed({3'b000, prod});
            y_next = '0;
            z_next = {{(ANG_W-32){a_f[31]}}, a_f};
        end else if (busy_reg) begin
            if (!z_reg[ANG_W-1]) begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - atan_turn(step_reg);
            end else begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + atan_turn(step_reg);
            end
        end

        step_next = step_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (start) begin
            step_next = '0;
            busy_next = 1'b1;
            done_next = 1'b0;
        end else if (busy_reg) begin
            step_next = step_reg + 4'd1;
            if (step_reg == 4'(CORDIC_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign done  = done_reg;
    assign x_out = x_reg;
    assign y_out = y_reg;
endmodule

// ===== src/sel_div.sv =====
module sel_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [sel_pkg::DIV_W-1:0]  dividend,
    input  logic [sel_pkg::DSR_W-1:0]  divisor,
    output logic                       done,
    output logic [sel_pkg::DIV_W-1:0]  quotient
);
    import sel_pkg::*;

    localparam int CW = $clog2(DIV_W + 1);

    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [DSR_W-1:0] rem_reg, rem_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             busy_reg, busy_next, done_reg, done_next;
    logic [DSR_W:0]   trial;
    logic [DSR_W:0]   diff;

    always_comb begin
        // restoring division, one quotient bit per cycle
        trial = {rem_reg, quo_reg[DIV_W-1]};
        diff  = trial - {1'b0, divisor};

        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
            done_next = 1'b0;
        end else if (busy_reg) begin
            if (trial >= {1'b0, divisor}) begin
                rem_next = diff[DSR_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b1};
            end else begin
                rem_next = trial[DSR_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + CW'(1);
            if (cnt_reg == CW'(DIV_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule

// ===== src/sel_checker.sv =====
module sel_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input sel_pkg::in_item_t  s_payload,
    input logic               m_valid,
    input logic               m_ready,
    input sel_pkg::out_item_t m_payload
);
    import sel_pkg::*;

    // reset drops the result
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("m_valid high after reset");

    // a beam item keeps the input closed for at least the next cycle
    a_beam_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_payload.command == CMD_BEAM |=> !s_ready)
        else $error("input open right after a beam item");

    // reported weight always lies inside the clamp range
    a_weight_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (SUM_W'(m_payload.weight_log2) >= LOW_SET) &&
                    (SUM_W'(m_payload.weight_log2) <= HIGH_SET))
        else $error("weight outside clamp range");

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_payload))
        else $error("result dropped or changed under stall");
endmodule

bind scan_endpoint_likelihood_top sel_checker u_sel_checker (.*);

// ===== tb/sv/scan_endpoint_likelihood_top_test.sv =====
`timescale 1ns / 100ps

module scan_endpoint_likelihood_top_test;
    import sel_pkg::*;

    localparam int SIDE       = 256;
    localparam int QUIET_MAX  = 5000;  // cycles with no item moving on either side
    localparam int SETTLE     = 100;
    localparam int LONG_HOLD  = 400;

    // atan(2^-i) in 2^-32 turn, for the CORDIC micro-rotations
    localparam longint ATAN_TURNS [16] = '{
        536870912, 316933406, 167458908, 85004756, 42667332, 21354465,
        10679842, 5340245, 2670163, 1335087, 667544, 333772, 166886,
        83443, 41722, 20861
    };

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_item_t    s_payload = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_item_t   m_payload;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    scan_endpoint_likelihood_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_payload(s_payload),
        .m_valid(m_valid), .m_ready(m_ready), .m_payload(m_payload),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 0;
    end

    // shadow of the configuration registers
    longint org_x = 0, org_y = 0, size_x = 256, size_y = 256;
    longint range_limit = 7680, gain = 24806;

    // predicted block state
    logic signed [15:0] grid_model [int];
    longint             scan_weight = 0;
    bit                 cell_loaded [int];   // cells that the stimulus has written

    in_item_t  pending_items [$];
    out_item_t expected_weights [$];

    bit idle_on = 1'b1;
    bit hold_req = 1'b0;
    int errors = 0;
    int pushed = 0;

    function automatic int cell_key(input logic [3:0] p, input int cx, input int cy);
        return (int'(p) << 16) | (cy << 8) | cx;
    endfunction

    function automatic longint ceil_div(input longint n, input longint d);
        if (n > 0)
            return (n + d - 1) / d;
        return -((-n) / d);
    endfunction

    // Beam end point and grid index; returns 1 when the beam is used at all.
    function automatic bit beam_endpoint(input in_item_t it, output bit on_map,
                                         output int cx, output int cy);
        logic [31:0] a;
        longint x, y, z, dx, dy, ix, iy, sx, sy;
        on_map = 1'b0;
        cx = 0;
        cy = 0;
        if (!(it.reading_index < 11'(SCAN_READINGS - 2) && (it.reading_index % 3) == 0
              && longint'(it.range_reading) < range_limit))
            return 1'b0;
        a = {it.pose_angle, 16'h0} + (32'(it.reading_index) + 32'd1) * BEAM_STEP
            + BEAM_OFFSET;
        x = longint'(it.range_reading) * longint'(CORDIC_KQ16);
        y = 0;
        // fold into the right half-plane first
        if (a >= 32'h4000_0000 && a < 32'hC000_0000) begin
            x = -x;
            a = a - 32'h8000_0000;
        end
        z = (a >= 32'h8000_0000) ? longint'(a) - (64'sd1 <<< 32) : longint'(a);
        for (int i = 0; i < 16; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= ATAN_TURNS[i];
            end else begin
                x += dx; y -= dy; z += ATAN_TURNS[i];
            end
        end
        sx = (size_x == 0) ? 1 : size_x;
        sy = (size_y == 0) ? 1 : size_y;
        ix = ceil_div((longint'(it.pose_x) - org_x) * 65536 + x, sx * 65536);
        iy = ceil_div((longint'(it.pose_y) - org_y) * 65536 + y, sy * 65536);
        // index 0 or below counts as off the map
        if (ix > 0 && iy > 0 && ix < SIDE && iy < SIDE) begin
            on_map = 1'b1;
            cx = int'(ix) - 1;
            cy = int'(iy) - 1;
        end
        return 1'b1;
    endfunction

    // Updates the predicted state for one accepted item.
    task automatic score_item(input in_item_t it);
        bit used, on_map;
        int cx, cy;
        longint c;
        out_item_t res;
        if (it.command == CMD_MAP_WRITE) begin
            grid_model[cell_key(it.particle, it.cell_x, it.cell_y)] = it.cell_value;
            return;
        end
        if (it.first_beam)
            scan_weight = 0;
        used = beam_endpoint(it, on_map, cx, cy);
        if (used) begin
            if (on_map) begin
                c = longint'(grid_model[cell_key(it.particle, cx, cy)]);
                if (c == longint'(ZERO_PROB))
                    scan_weight = longint'(LOW_SET);
                else
                    scan_weight += gain + c * 64;
            end
            if (scan_weight < longint'(LOW_LIMIT))
                scan_weight = longint'(LOW_SET);
            else if (scan_weight > longint'(HIGH_LIMIT))
                scan_weight = longint'(HIGH_SET);
        end
        if (it.last_beam) begin
            res.particle_out = it.particle;
            res.weight_log2  = scan_weight[23:0];
            expected_weights.push_back(res);
        end
    endtask

    function automatic logic signed [15:0] rand_log_prob();
        case ($urandom_range(0, 7))
            0: return ZERO_PROB;
            1: return 16'sd0;
            default: return 16'(-int'($urandom_range(0, 32767)));
        endcase
    endfunction

    function automatic longint clip24(input longint v);
        if (v > 8388607)
            return 8388607;
        if (v < -8388608)
            return -8388608;
        return v;
    endfunction

    task automatic push_write(input logic [3:0] p, input int cx, input int cy,
                              input logic signed [15:0] v);
        in_item_t it;
        it = in_item_t'({$urandom, $urandom, $urandom, $urandom});
        it.command = CMD_MAP_WRITE;
        it.particle = p;
        it.cell_x = 8'(cx);
        it.cell_y = 8'(cy);
        it.cell_value = v;
        it.reading_index = 11'($urandom_range(0, 1079));
        cell_loaded[cell_key(p, cx, cy)] = 1'b1;
        pending_items.push_back(it);
        pushed++;
    endtask

    // Queues a beam; a cell it lands on is loaded first if it never was, or with v if force_cell.
    task automatic push_beam(input in_item_t it, input bit force_cell,
                             input logic signed [15:0] v);
        bit on_map;
        int cx, cy;
        if (beam_endpoint(it, on_map, cx, cy) && on_map
            && (force_cell || !cell_loaded.exists(cell_key(it.particle, cx, cy))))
            push_write(it.particle, cx, cy, force_cell ? v : rand_log_prob());
        pending_items.push_back(it);
        pushed++;
    endtask

    // Beam with a pose somewhere over the current grid, random filler fields.
    function automatic in_item_t make_beam(input logic [3:0] p, input int idx,
                                           input bit first, input bit last);
        in_item_t it;
        longint rmax;
        it = in_item_t'({$urandom, $urandom, $urandom, $urandom});
        it.command = CMD_BEAM;
        it.particle = p;
        it.pose_x = 24'(clip24(org_x + longint'($urandom_range(0, 256 * int'(size_x)))));
        it.pose_y = 24'(clip24(org_y + longint'($urandom_range(0, 256 * int'(size_y)))));
        it.pose_angle = 16'($urandom);
        it.reading_index = 11'(idx);
        rmax = ((size_x > size_y) ? size_x : size_y) * 40;
        if (rmax > 65535 || $urandom_range(0, 15) == 0)
            rmax = 65535;
        it.range_reading = 16'($urandom_range(0, int'(rmax)));
        it.first_beam = first;
        it.last_beam = last;
        return it;
    endfunction

    task automatic random_items(input int target, input int max_scan);
        in_item_t it;
        int len, k;
        while (pushed < target) begin
            case ($urandom_range(0, 9))
                0: push_write(4'($urandom), $urandom_range(0, 255), $urandom_range(0, 255),
                              rand_log_prob());
                1: begin
                    // noise: arbitrary pose and range, reading number anywhere in 0 to 1079
                    it = in_item_t'({$urandom, $urandom, $urandom, $urandom});
                    it.command = CMD_BEAM;
                    it.reading_index = 11'($urandom_range(0, 1079));
                    push_beam(it, 1'b0, 16'sd0);
                end
                default: begin
                    len = $urandom_range(1, max_scan);
                    k = $urandom_range(0, 20);
                    it.particle = 4'($urandom);
                    for (int b = 0; b < len; b++) begin
                        // now and then a scan without its opening flag
                        it = make_beam(it.particle, 3 * (k % 360),
                                       b == 0 && $urandom_range(0, 15) != 0, b == len - 1);
                        // a stray reading number, possibly not a multiple of three
                        if ($urandom_range(0, 11) == 0)
                            it.reading_index = 11'($urandom_range(0, 1079));
                        push_beam(it, 1'b0, 16'sd0);
                        k += $urandom_range(1, 6);
                    end
                end
            endcase
        end
    endtask

    task automatic reg_write(input logic [2:0] idx, input longint value);
        @(posedge aclk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= 32'(value);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_ORIGIN_X:    org_x = value;
            REG_ORIGIN_Y:    org_y = value;
            REG_CELL_SIZE_X: size_x = value;
            REG_CELL_SIZE_Y: size_y = value;
            REG_MAX_RANGE:   range_limit = value;
            default:         gain = value;
        endcase
    endtask

    // sender waits here until every result is back and the block has settled
    task automatic drain();
        while (pending_items.size() != 0 || s_valid || expected_weights.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic configure(input longint ox, input longint oy, input longint sx,
                             input longint sy, input longint mr, input longint lg);
        drain();
        reg_write(REG_ORIGIN_X, ox);
        reg_write(REG_ORIGIN_Y, oy);
        reg_write(REG_CELL_SIZE_X, sx);
        reg_write(REG_CELL_SIZE_Y, sy);
        reg_write(REG_MAX_RANGE, mr);
        reg_write(REG_LOG_GAIN, lg);
    endtask

    // Driver: valid held with a steady payload until taken; random gaps.
    int send_gap = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (send_gap > 0) begin
                send_gap--;
                s_valid <= 1'b0;
            end else if (pending_items.size() != 0) begin
                s_payload <= pending_items.pop_front();
                s_valid <= 1'b1;
                if (idle_on && $urandom_range(0, 9) == 0)
                    send_gap = $urandom_range(1, 14);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Monitor: predicts on each accepted item, checks each result, drives m_ready.
    int hold_cnt = 0;
    int stall_cnt = 0;
    out_item_t want;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                score_item(s_payload);
            if (m_valid && m_ready) begin
                if (expected_weights.size() == 0) begin
                    $error("unexpected result: particle %0d weight %0d",
                           m_payload.particle_out, m_payload.weight_log2);
                    errors++;
                end else begin
                    want = expected_weights.pop_front();
                    if (m_payload.particle_out !== want.particle_out) begin
                        $error("particle_out: expected %0d, got %0d",
                               want.particle_out, m_payload.particle_out);
                        errors++;
                    end
                    if (m_payload.weight_log2 !== want.weight_log2) begin
                        $error("weight_log2: expected %0d, got %0d",
                               want.weight_log2, m_payload.weight_log2);
                        errors++;
                    end
                end
            end
        end
        if (hold_req) begin
            hold_req = 1'b0;
            hold_cnt = LONG_HOLD;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            m_ready <= 1'b0;
        end else if (stall_cnt > 0) begin
            stall_cnt--;
            m_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_cnt = $urandom_range(0, 13);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Watchdog on cycles where nothing moves on either channel
    int quiet = 0;
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            quiet = 0;
        else
            quiet++;
        if (quiet == QUIET_MAX) begin
            $display("scan_endpoint_likelihood_top_test failed");
            $finish;
        end
    end

    in_item_t d;
    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part at reset settings: 1 m cells, origin 0, range limit 30 m
        push_write(4'd0, 0, 0, 16'sd0);
        push_write(4'd15, 255, 255, ZERO_PROB);
        d = make_beam(4'd0, 0, 1'b1, 1'b0);
        d.pose_x = 24'sd25600; d.pose_y = 24'sd25600;
        d.pose_angle = 16'd0; d.range_reading = 16'd0;
        push_beam(d, 1'b0, 16'sd0);
        d.reading_index = 11'd1077; d.pose_angle = 16'hFFFF; d.range_reading = 16'd7679;
        d.first_beam = 1'b0;
        push_beam(d, 1'b0, 16'sd0);
        d.range_reading = 16'd7680;           // at the limit: skipped
        push_beam(d, 1'b0, 16'sd0);
        d.range_reading = 16'hFFFF;
        push_beam(d, 1'b0, 16'sd0);
        d.range_reading = 16'd1000;
        d.reading_index = 11'd1;              // not a multiple of three
        push_beam(d, 1'b0, 16'sd0);
        d.reading_index = 11'd1078;           // past the last used reading
        push_beam(d, 1'b0, 16'sd0);
        d.reading_index = 11'd1079;
        d.last_beam = 1'b1;
        push_beam(d, 1'b0, 16'sd0);
        // zero-probability cell pins the weight to the floor
        d = make_beam(4'd7, 300, 1'b1, 1'b0);
        d.range_reading = 16'd2000;
        push_beam(d, 1'b1, ZERO_PROB);
        d.reading_index = 11'd303;
        d.last_beam = 1'b1;
        push_beam(d, 1'b1, 16'sd0);
        // pose far off the map on both sides
        d = make_beam(4'd15, 0, 1'b1, 1'b1);
        d.pose_x = -24'sd8388608; d.pose_y = 24'sd8388607;
        push_beam(d, 1'b0, 16'sd0);
        d.pose_x = 24'sd8388607; d.pose_y = -24'sd8388608;
        push_beam(d, 1'b0, 16'sd0);
        // a short scan with a beam on the highest cell value
        for (int b = 0; b < 4; b++) begin
            d = make_beam(4'd15, 3 * b, b == 0, b == 3);
            d.range_reading = 16'd500;
            push_beam(d, 1'b1, (b == 1) ? 16'sd0 : -16'sd1);
        end
        random_items(320, 20);

        // tiny cells, extreme origin, no range limit, strongest negative gain
        configure(-8388608, -5000000, 1, 3, 65535, -65536);
        random_items(650, 20);

        // every beam skipped; a zero cell size acts as one
        configure(8388607, 8388607, 65535, 0, 0, 65535);
        random_items(750, 12);

        // long scans with the largest gain drive the weight into the upper clamp;
        // the receiver holds off long enough to back up the input side
        configure(-300000, 200000, 100, 100, 30000, 65535);
        hold_req = 1'b1;
        random_items(1250, 45);

        // back to reset values, no idling to the end
        configure(0, 0, 256, 256, 7680, 24806);
        idle_on = 1'b0;
        random_items(1700, 20);
        drain();

        if (errors == 0)
            $display("scan_endpoint_likelihood_top_test passed");
        else
            $display("scan_endpoint_likelihood_top_test failed");
        $finish;
    end

endmodule
